// ===== design/atp_pkg.sv =====
package atp_pkg;

   localparam int CoeffWidth  = 16;
   localparam int ScaleWidth  = 4;
   localparam int WordWidth   = 32;
   localparam int CsrIdxWidth = 3;
   localparam int CentiScale  = 100;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_QUAD_COEFF  = 3'd0,
      CSR_LIN_COEFF   = 3'd1,
      CSR_PTAT_AT_25C = 3'd2,
      CSR_LIN_SCALE   = 3'd3,
      CSR_QUAD_SCALE  = 3'd4
   } csr_idx_type;

   // root cell: remainder, partial result and operand words
   typedef struct packed {
      logic                         valid;
      logic                         err;
      logic [WordWidth-1:0]         rem;
      logic [WordWidth-1:0]         res;
      logic signed [CoeffWidth-1:0] b;
      logic signed [CoeffWidth-1:0] a;
      logic [4:0]                   sh2;
   } root_type;

   // divide cell: magnitudes and signs, remainder and quotient bits
   typedef struct packed {
      logic                 valid;
      logic                 err;
      logic                 neg;
      logic [WordWidth-1:0] num;
      logic [WordWidth:0]   rem;
      logic [CoeffWidth-1:0] den;
   } div_type;

endpackage

// ===== design/ambient_temperature_from_ptat_top.sv =====
// ambient temperature from a raw ptat word: one item in, one item out, gives
// ambient minus 25 C in 0.01 C steps by solving the calibration quadratic.
// the datapath is a chain of cells: one input stage (multiply and shift), one
// stage for b*b + q, 16 square root cells, one rounding/scaling stage, one
// times-100 and sign stage, 32 restoring divide cells and the output register.
// a new item can be taken every cycle unless the result side stalls, which holds
// the whole chain. a zero quadratic coefficient or a scale pair giving a shift
// outside 0..31 yields zero with param_error set.
module ambient_temperature_from_ptat_top
   import atp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [CoeffWidth-1:0]         req_ptat_raw,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [WordWidth-1:0]   rsp_ambient_delta_centi,
   output logic                          rsp_param_error,
   input  logic                          csr_we,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [CoeffWidth-1:0]         csr_wdata
);
   logic signed [CoeffWidth-1:0] a_ff, b_ff, vth_ff;
   logic [ScaleWidth-1:0]        k1_ff, k2_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; vth_ff <= '0; k1_ff <= '0; k2_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_QUAD_COEFF:  a_ff   <= csr_wdata;
            CSR_LIN_COEFF:   b_ff   <= csr_wdata;
            CSR_PTAT_AT_25C: vth_ff <= csr_wdata;
            CSR_LIN_SCALE:   k1_ff  <= csr_wdata[ScaleWidth-1:0];
            CSR_QUAD_SCALE:  k2_ff  <= csr_wdata[ScaleWidth-1:0];
            default: ;
         endcase
      end
   end

   // whole chain advances unless the output holds an untaken item
   logic stall;
   assign stall     = rsp_valid && !rsp_ready;
   assign req_ready = !stall;

   // shift amounts: s = k2-k1, sh1 = 2*k1 + 2 - k2, sh2 = s - 1
   logic signed [6:0] s_w, sh1_w, sh2_w;
   logic              err_w;
   always_comb begin
      s_w   = 7'(signed'({1'b0, k2_ff})) - 7'(signed'({1'b0, k1_ff}));
      sh1_w = 7'(signed'({1'b0, k1_ff})) + 7'sd2 - s_w;
      sh2_w = s_w - 7'sd1;
      err_w = (a_ff == '0) || sh1_w < 0 || sh1_w > 31 || sh2_w < 0 || sh2_w > 31;
   end

   // stage 0: c and q
   logic signed [CoeffWidth-1:0] c_w;
   logic [WordWidth-1:0]         q_w;
   assign c_w = vth_ff - signed'(req_ptat_raw);
   assign q_w = (WordWidth'(signed'(a_ff)) * (WordWidth'(0) - WordWidth'(signed'(c_w))))
                << sh1_w[4:0];

   logic                         s0_valid_ff, s0_err_ff;
   logic [WordWidth-1:0]         s0_q_ff;
   logic signed [CoeffWidth-1:0] s0_a_ff, s0_b_ff;
   logic [4:0]                   s0_sh2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (!stall) begin
         s0_valid_ff <= req_valid;
         s0_err_ff   <= err_w;
         s0_q_ff     <= q_w;
         s0_a_ff     <= a_ff;
         s0_b_ff     <= b_ff;
         s0_sh2_ff   <= sh2_w[4:0];
      end
   end

   // stage 1: x = b*b + q
   root_type root_in, root_ff;
   always_comb begin
      root_in.valid = s0_valid_ff;
      root_in.err   = s0_err_ff;
      root_in.rem   = WordWidth'(signed'(s0_b_ff)) * WordWidth'(signed'(s0_b_ff)) + s0_q_ff;
      root_in.res   = '0;
      root_in.b     = s0_b_ff;
      root_in.a     = s0_a_ff;
      root_in.sh2   = s0_sh2_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff.valid <= 1'b0;
      end else if (!stall) begin
         root_ff <= root_in;
      end
   end

   // square root cells, one result bit each
   root_type rchain [0:16];
   assign rchain[0] = root_ff;
   for (genvar i = 0; i < 16; i++) begin : g_root
      atp_root_cell #(.Step(i)) u_cell (
         .clock, .reset, .stall, .d_in(rchain[i]), .d_out(rchain[i+1])
      );
   end

   // rounding and scaling
   root_type rt;
   logic [WordWidth-1:0] r_w, d_w;
   assign rt  = rchain[16];
   assign r_w = rt.res + WordWidth'(rt.rem > rt.res);
   assign d_w = (r_w - WordWidth'(signed'(rt.b))) << rt.sh2;

   logic                         sc_valid_ff, sc_err_ff;
   logic [WordWidth-1:0]         sc_d_ff;
   logic signed [CoeffWidth-1:0] sc_a_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (!stall) begin
         sc_valid_ff <= rt.valid;
         sc_err_ff   <= rt.err;
         sc_d_ff     <= d_w;
         sc_a_ff     <= rt.a;
      end
   end

   // times 100, then magnitudes for the divider
   logic [WordWidth-1:0] p_w, pmag_w;
   logic [CoeffWidth-1:0] amag_w;
   assign p_w    = sc_d_ff * WordWidth'(CentiScale);
   assign pmag_w = p_w[WordWidth-1] ? (WordWidth'(0) - p_w) : p_w;
   assign amag_w = sc_a_ff[CoeffWidth-1] ? (CoeffWidth'(0) - sc_a_ff) : sc_a_ff;

   div_type div_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else if (!stall) begin
         div_ff.valid <= sc_valid_ff;
         div_ff.err   <= sc_err_ff;
         div_ff.neg   <= p_w[WordWidth-1] ^ sc_a_ff[CoeffWidth-1];
         div_ff.num   <= pmag_w;
         div_ff.rem   <= '0;
         div_ff.den   <= amag_w;
      end
   end

   // restoring divide cells, one quotient bit each
   div_type dchain [0:WordWidth];
   assign dchain[0] = div_ff;
   for (genvar j = 0; j < WordWidth; j++) begin : g_div
      atp_div_cell u_cell (
         .clock, .reset, .stall, .d_in(dchain[j]), .d_out(dchain[j+1])
      );
   end

   // sign and error applied into the output register
   div_type dv;
   assign dv = dchain[WordWidth];
   logic [WordWidth-1:0] quo_w;
   assign quo_w = dv.neg ? (WordWidth'(0) - dv.num) : dv.num;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (!stall) begin
         rsp_valid               <= dv.valid;
         rsp_param_error         <= dv.err;
         rsp_ambient_delta_centi <= dv.err ? '0 : signed'(quo_w);
      end
   end

   // a held result keeps its value while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      $past(stall) |-> $stable(rsp_ambient_delta_centi) && rsp_valid)
      else $error("result changed while stalled");
   // error results carry zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_param_error |-> rsp_ambient_delta_centi == '0)
      else $error("error result not zero");
   // no input is taken while the output is held
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      stall |-> !req_ready)
      else $error("input taken during stall");
endmodule

// ===== design/atp_root_cell.sv =====
module atp_root_cell
   import atp_pkg::*;
#(
   parameter int Step = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     stall,
   input  root_type d_in,
   output root_type d_out
);
   localparam logic [WordWidth-1:0] Bit = WordWidth'(1) << (2 * (15 - Step));

   root_type nxt_in, nxt_ff;
   logic [WordWidth-1:0] trial;

   always_comb begin
      nxt_in = d_in;
      trial  = d_in.res + Bit;
      if (d_in.rem >= trial) begin
         nxt_in.rem = d_in.rem - trial;
         nxt_in.res = (d_in.res >> 1) + Bit;
      end else begin
         nxt_in.res = d_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_ff.valid <= 1'b0;
      end else if (!stall) begin
         nxt_ff <= nxt_in;
      end
   end

   assign d_out = nxt_ff;
endmodule

// ===== design/atp_div_cell.sv =====
module atp_div_cell
   import atp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    stall,
   input  div_type d_in,
   output div_type d_out
);
   div_type nxt_in, nxt_ff;
   logic [WordWidth:0] sh;
   logic [WordWidth:0] dif;

   always_comb begin
      nxt_in = d_in;
      sh  = {d_in.rem[WordWidth-1:0], d_in.num[WordWidth-1]};
      dif = sh - {{(WordWidth-CoeffWidth+1){1'b0}}, d_in.den};
      nxt_in.num = d_in.num << 1;
      if (!dif[WordWidth]) begin
         nxt_in.rem    = dif;
         nxt_in.num[0] = 1'b1;
      end else begin
         nxt_in.rem = sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_ff.valid <= 1'b0;
      end else if (!stall) begin
         nxt_ff <= nxt_in;
      end
   end

   assign d_out = nxt_ff;
endmodule

// ===== sim/tb_ambient_temperature_from_ptat_top.sv =====
`timescale 1ns / 1ps

module tb_ambient_temperature_from_ptat_top;
   import atp_pkg::*;

   // one expected result item
   typedef struct {
      logic signed [WordWidth-1:0] delta;
      logic                        err;
   } temp_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [CoeffWidth-1:0]       req_ptat_raw = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [WordWidth-1:0] rsp_ambient_delta_centi;
   logic                        rsp_param_error;
   logic                        csr_we = 1'b0;
   logic [CsrIdxWidth-1:0]      csr_index = CSR_QUAD_COEFF;
   logic [CoeffWidth-1:0]       csr_wdata = '0;

   ambient_temperature_from_ptat_top dut (.*);

   always #5 clock = ~clock;

   // shadow copy of the calibration registers
   logic signed [CoeffWidth-1:0] cal_a, cal_b, cal_vth;
   logic [ScaleWidth-1:0]        cal_k1, cal_k2;

   logic [CoeffWidth-1:0] ptat_pending[$];
   temp_result_type       temp_expected[$];
   int unsigned           fail_count = 0;
   longint unsigned       cycle_count = 0;
   bit                    quiet_phase = 0;
   bit                    hold_off = 0;
   int                    send_gap = 0;
   int                    recv_gap = 0;
   int                    hold_cycles = 0;

   // rounded integer square root, bit by bit
   function automatic logic [31:0] round_root(input logic [31:0] x);
      logic [31:0] rem, res, bitv;
      rem = x; res = 0; bitv = 32'h4000_0000;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      if (rem > res) res = res + 1;
      return res;
   endfunction

   // ambient delta for one ptat word under the current calibration
   function automatic temp_result_type ambient_delta(input logic [CoeffWidth-1:0] ptat);
      temp_result_type t;
      int s, sh1, sh2;
      logic signed [15:0] c;
      logic [31:0] q, x, r, d, a32, b32;
      longint p, quo;
      s = int'(cal_k2) - int'(cal_k1);
      sh1 = int'(cal_k1) + 2 - s;
      sh2 = s - 1;
      t.delta = 0; t.err = 1;
      if (cal_a == 0 || sh1 < 0 || sh1 > 31 || sh2 < 0 || sh2 > 31) return t;
      c = cal_vth - ptat;
      a32 = 32'(cal_a);
      b32 = 32'(cal_b);
      q = (a32 * (32'(-32'sd0) - 32'(c))) << sh1;
      x = b32 * b32 + q;
      r = round_root(x);
      d = (r - b32) << sh2;
      d = d * 32'(CentiScale);
      p = longint'($signed(d));
      quo = p / longint'(cal_a);
      t.delta = quo[31:0];
      t.err = 0;
      return t;
   endfunction

   // driver: offers pending items with random bursts of idling
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            temp_expected.push_back(ambient_delta(req_ptat_raw));
            void'(ptat_pending.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold the offered item
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 14) - 1;
            req_valid <= 1'b0;
         end else if (ptat_pending.size() > 0) begin
            req_valid <= 1'b1;
            req_ptat_raw <= ptat_pending[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls, with a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         recv_gap <= $urandom_range(1, 14) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: compares each accepted result item with the oldest expectation
   always @(posedge clock) begin
      temp_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (temp_expected.size() == 0) begin
            $display("%0t: unexpected item delta=%0d err=%0b", $time,
                     rsp_ambient_delta_centi, rsp_param_error);
            fail_count++;
         end else begin
            e = temp_expected.pop_front();
            if (e.delta !== rsp_ambient_delta_centi) begin
               $display("%0t: delta expected %0d actual %0d", $time, e.delta,
                        rsp_ambient_delta_centi);
               fail_count++;
            end
            if (e.err !== rsp_param_error) begin
               $display("%0t: param_error expected %0b actual %0b", $time, e.err,
                        rsp_param_error);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_csr(input csr_idx_type idx, input logic [CoeffWidth-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_QUAD_COEFF:  cal_a = val;
         CSR_LIN_COEFF:   cal_b = val;
         CSR_PTAT_AT_25C: cal_vth = val;
         CSR_LIN_SCALE:   cal_k1 = val[ScaleWidth-1:0];
         CSR_QUAD_SCALE:  cal_k2 = val[ScaleWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_calibration(input logic [15:0] a, input logic [15:0] b,
                                  input logic [15:0] vth, input logic [3:0] k1,
                                  input logic [3:0] k2);
      write_csr(CSR_QUAD_COEFF, a);
      write_csr(CSR_LIN_COEFF, b);
      write_csr(CSR_PTAT_AT_25C, vth);
      write_csr(CSR_LIN_SCALE, {12'd0, k1});
      write_csr(CSR_QUAD_SCALE, {12'd0, k2});
   endtask

   // wait until every expected item has come back
   task automatic drain();
      while (ptat_pending.size() != 0 || req_valid || temp_expected.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_words(input int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: ptat_pending.push_back(16'(cal_vth + $urandom_range(0, 64) - 32));
            1: ptat_pending.push_back($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            default: ptat_pending.push_back(16'($urandom_range(0, 16'hFFFF)));
         endcase
      end
   endtask

   initial begin
      cal_a = 0; cal_b = 0; cal_vth = 0; cal_k1 = 0; cal_k2 = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset values: zero coefficient gives the error flag
      ptat_pending.push_back(16'h1234);
      ptat_pending.push_back(16'h0000);
      drain();

      // typical calibration and extremes of the word
      set_calibration(16'hF000, 16'd22000, 16'd12000, 4'd8, 4'd14);
      ptat_pending.push_back(16'h0000);
      ptat_pending.push_back(16'hFFFF);
      ptat_pending.push_back(16'd12000);
      ptat_pending.push_back(16'h8000);
      ptat_pending.push_back(16'h7FFF);
      drain();
      // k2 below k1 and k2 == k1: shift out of range
      set_calibration(16'd100, 16'd5, 16'd0, 4'd9, 4'd3);
      ptat_pending.push_back(16'd7);
      drain();
      write_csr(CSR_QUAD_SCALE, 16'd9);
      ptat_pending.push_back(16'd7);
      drain();
      // extreme coefficients, quotient overflow case with a = -1
      set_calibration(16'hFFFF, 16'h8000, 16'h7FFF, 4'd0, 4'd1);
      ptat_pending.push_back(16'h0000);
      ptat_pending.push_back(16'hFFFF);
      ptat_pending.push_back(16'h8001);
      drain();
      set_calibration(16'h7FFF, 16'h7FFF, 16'h8000, 4'd15, 4'd15);
      ptat_pending.push_back(16'h1);
      drain();
      write_csr(CSR_LIN_SCALE, 16'd0);
      write_csr(CSR_QUAD_SCALE, 16'd15);
      ptat_pending.push_back(16'h1);
      drain();
      write_csr(CSR_LIN_SCALE, 16'd10);
      ptat_pending.push_back(16'h5555);
      ptat_pending.push_back(16'hAAAA);
      drain();

      // long stall on the result side while items keep coming
      set_calibration(16'hF123, 16'd20000, 16'd13000, 4'd8, 4'd13);
      hold_off = 1;
      random_words(150);
      while (hold_cycles < 300) @(posedge clock);
      hold_off = 0;
      drain();

      // random phases with random calibrations
      for (int ph = 0; ph < 12; ph++) begin
         if ($urandom_range(0, 3) != 0) begin
            // plausible sensor calibration
            set_calibration(16'($urandom_range(1, 32767) | 16'h8000 * $urandom_range(0, 1)),
                            16'($urandom_range(0, 16'hFFFF)),
                            16'($urandom_range(0, 16'hFFFF)),
                            4'($urandom_range(0, 12)), 4'($urandom_range(0, 15)));
            if (cal_k2 <= cal_k1) write_csr(CSR_QUAD_SCALE, {12'd0, 4'(cal_k1 + 1)});
         end else begin
            set_calibration(16'($urandom_range(0, 16'hFFFF)),
                            16'($urandom_range(0, 16'hFFFF)),
                            16'($urandom_range(0, 16'hFFFF)),
                            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end
         if (ph >= 10) quiet_phase = 1;
         random_words(107);
         drain();
      end

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
